>>> sv/via_pkg.sv
package via_pkg;

   // item kinds on the request channel
   typedef enum logic [2:0] {
      MODE_READ    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_TICK    = 3'd2,
      MODE_PORT_A  = 3'd3,
      MODE_PORT_B  = 3'd4,
      MODE_CA1     = 3'd5,
      MODE_CB1     = 3'd6,
      MODE_NONE    = 3'd7
   } mode_type;

   // register map
   typedef enum logic [3:0] {
      REG_ORB    = 4'd0,
      REG_ORA    = 4'd1,
      REG_DDRB   = 4'd2,
      REG_DDRA   = 4'd3,
      REG_T1C_L  = 4'd4,
      REG_T1C_H  = 4'd5,
      REG_T1L_L  = 4'd6,
      REG_T1L_H  = 4'd7,
      REG_T2C_L  = 4'd8,
      REG_T2C_H  = 4'd9,
      REG_SR     = 4'd10,
      REG_ACR    = 4'd11,
      REG_PCR    = 4'd12,
      REG_IFR    = 4'd13,
      REG_IER    = 4'd14,
      REG_ORA_NH = 4'd15
   } reg_index_type;

   // interrupt flag bits (bit 7 of IFR is the composite, computed)
   localparam logic [6:0] FLAG_CA2 = 7'h01;
   localparam logic [6:0] FLAG_CA1 = 7'h02;
   localparam logic [6:0] FLAG_CB2 = 7'h08;
   localparam logic [6:0] FLAG_CB1 = 7'h10;
   localparam logic [6:0] FLAG_T2  = 7'h20;
   localparam logic [6:0] FLAG_T1  = 7'h40;

   // auxiliary control bits
   localparam int ACR_PB7_OUT   = 7;
   localparam int ACR_T1_FREE   = 6;
   localparam int ACR_T2_PULSE  = 5;

   // peripheral control edge select bits
   localparam int PCR_CA1_RISE  = 0;
   localparam int PCR_CB1_RISE  = 4;

   localparam logic [15:0] TIMER_STOPPED = 16'hFFFF;
   localparam logic [7:0]  EXT_RESET     = 8'hFF;

endpackage

>>> sv/versatile_interface_adapter_core.sv
// 6522-style parallel interface adapter, one request in, one response out.
// request channel (req_*): mode selects a bus read, a bus write, a timer tick
// of req_tick_cycles cycles, a new port A or port B input level, or a new CA1
// or CB1 level. each accepted transfer produces exactly one response transfer.
// response channel (rsp_*): read data (zero unless a read), the interrupt line
// (also high on a tick in which a timer expired) and both port pin levels as
// they stand after the request.
// the response is registered and is valid in the cycle after the request transfer.
// throughput: one request per cycle while the response is not stalled; all state
// updates for a request are registered together with the response register.
// a stalled response is held in the response register; a new request is
// taken whenever that register is empty or is being emptied in the same
// cycle, so req_stall follows rsp_stall only while a response is waiting.
// reset (synchronous, active high) clears the state registers, sets the external
// port levels to all ones and CA1/CB1 high, and empties the response register.
module versatile_interface_adapter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_tick_cycles,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_out,
   output logic [7:0]  rsp_port_a_pins,
   output logic [7:0]  rsp_port_b_pins
);

   // architectural state
   logic [7:0]  ora_ff, ora_in, orb_ff, orb_in;
   logic [7:0]  ddra_ff, ddra_in, ddrb_ff, ddrb_in;
   logic [7:0]  ext_a_ff, ext_a_in, ext_b_ff, ext_b_in;
   logic [15:0] t1_latch_ff, t1_latch_in, t1_count_ff, t1_count_in;
   logic        t1_run_ff, t1_run_in, t1_pb7_ff, t1_pb7_in;
   logic [7:0]  t2_low_ff, t2_low_in;
   logic [15:0] t2_count_ff, t2_count_in;
   logic        t2_run_ff, t2_run_in;
   logic [7:0]  sr_ff, sr_in, acr_ff, acr_in, pcr_ff, pcr_in;
   logic [6:0]  flags_ff, flags_in, ier_ff, ier_in;
   logic        ca1_ff, ca1_in, cb1_ff, cb1_in;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  rd_ff, rd_in;
   logic        irq_ff, irq_in;
   logic [7:0]  pins_a_ff, pins_a_in, pins_b_ff, pins_b_in;

   logic        accept;
   logic        fired;
   logic [7:0]  pins_a_cur, pins_b_cur;
   logic        t1_expire, t2_expire;

   // transfer handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // pin levels from the current state
   always_comb begin
      pins_a_cur = (ora_ff & ddra_ff) | (ext_a_ff & ~ddra_ff);
      pins_b_cur = (orb_ff & ddrb_ff) | (ext_b_ff & ~ddrb_ff);
      if (acr_ff[via_pkg::ACR_PB7_OUT]) begin
         pins_b_cur[7] = t1_pb7_ff;
      end
   end

   assign t1_expire = t1_run_ff && (t1_count_ff <= req_tick_cycles);
   assign t2_expire = t2_run_ff && !acr_ff[via_pkg::ACR_T2_PULSE]
                      && (t2_count_ff <= req_tick_cycles);

   // next state and response for one request
   always_comb begin
      ora_in      = ora_ff;
      orb_in      = orb_ff;
      ddra_in     = ddra_ff;
      ddrb_in     = ddrb_ff;
      ext_a_in    = ext_a_ff;
      ext_b_in    = ext_b_ff;
      t1_latch_in = t1_latch_ff;
      t1_count_in = t1_count_ff;
      t1_run_in   = t1_run_ff;
      t1_pb7_in   = t1_pb7_ff;
      t2_low_in   = t2_low_ff;
      t2_count_in = t2_count_ff;
      t2_run_in   = t2_run_ff;
      sr_in       = sr_ff;
      acr_in      = acr_ff;
      pcr_in      = pcr_ff;
      flags_in    = flags_ff;
      ier_in      = ier_ff;
      ca1_in      = ca1_ff;
      cb1_in      = cb1_ff;
      rd_in       = 8'h00;
      fired       = 1'b0;

      case (req_mode)
         via_pkg::MODE_READ: begin
            case (req_reg_index)
               via_pkg::REG_ORB: begin
                  rd_in    = pins_b_cur;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CB1 | via_pkg::FLAG_CB2);
               end
               via_pkg::REG_ORA: begin
                  rd_in    = pins_a_cur;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CA1 | via_pkg::FLAG_CA2);
               end
               via_pkg::REG_DDRB:  rd_in = ddrb_ff;
               via_pkg::REG_DDRA:  rd_in = ddra_ff;
               via_pkg::REG_T1C_L: begin
                  rd_in    = t1_count_ff[7:0];
                  flags_in = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T1C_H: rd_in = t1_count_ff[15:8];
               via_pkg::REG_T1L_L: rd_in = t1_latch_ff[7:0];
               via_pkg::REG_T1L_H: rd_in = t1_latch_ff[15:8];
               via_pkg::REG_T2C_L: begin
                  rd_in    = t2_count_ff[7:0];
                  flags_in = flags_ff & ~via_pkg::FLAG_T2;
               end
               via_pkg::REG_T2C_H: rd_in = t2_count_ff[15:8];
               via_pkg::REG_SR:    rd_in = sr_ff;
               via_pkg::REG_ACR:   rd_in = acr_ff;
               via_pkg::REG_PCR:   rd_in = pcr_ff;
               via_pkg::REG_IFR:   rd_in = {|(flags_ff & ier_ff), flags_ff};
               via_pkg::REG_IER:   rd_in = {1'b1, ier_ff};
               default:            rd_in = pins_a_cur;
            endcase
         end
         via_pkg::MODE_WRITE: begin
            case (req_reg_index)
               via_pkg::REG_ORB: begin
                  orb_in   = req_write_data;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CB1 | via_pkg::FLAG_CB2);
               end
               via_pkg::REG_ORA: begin
                  ora_in   = req_write_data;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CA1 | via_pkg::FLAG_CA2);
               end
               via_pkg::REG_DDRB:  ddrb_in = req_write_data;
               via_pkg::REG_DDRA:  ddra_in = req_write_data;
               via_pkg::REG_T1C_L: t1_latch_in = {t1_latch_ff[15:8], req_write_data};
               via_pkg::REG_T1C_H: begin
                  // load counter from latch and start
                  t1_latch_in = {req_write_data, t1_latch_ff[7:0]};
                  t1_count_in = {req_write_data, t1_latch_ff[7:0]};
                  t1_run_in   = 1'b1;
                  flags_in    = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T1L_L: t1_latch_in = {t1_latch_ff[15:8], req_write_data};
               via_pkg::REG_T1L_H: begin
                  t1_latch_in = {req_write_data, t1_latch_ff[7:0]};
                  flags_in    = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T2C_L: t2_low_in = req_write_data;
               via_pkg::REG_T2C_H: begin
                  t2_count_in = {req_write_data, t2_low_ff};
                  t2_run_in   = 1'b1;
                  flags_in    = flags_ff & ~via_pkg::FLAG_T2;
               end
               via_pkg::REG_SR:    sr_in  = req_write_data;
               via_pkg::REG_ACR:   acr_in = req_write_data;
               via_pkg::REG_PCR:   pcr_in = req_write_data;
               via_pkg::REG_IFR:   flags_in = flags_ff & ~req_write_data[6:0];
               via_pkg::REG_IER: begin
                  // bit 7 selects set or clear of the named enables
                  if (req_write_data[7]) begin
                     ier_in = ier_ff | req_write_data[6:0];
                  end else begin
                     ier_in = ier_ff & ~req_write_data[6:0];
                  end
               end
               default:            ora_in = req_write_data;
            endcase
         end
         via_pkg::MODE_TICK: begin
            // timer 1: reload in free-run mode, else stop
            if (t1_run_ff) begin
               if (t1_expire) begin
                  fired = 1'b1;
                  if (acr_ff[via_pkg::ACR_T1_FREE]) begin
                     t1_count_in = t1_latch_ff;
                     if (acr_ff[via_pkg::ACR_PB7_OUT]) begin
                        t1_pb7_in = ~t1_pb7_ff;
                     end
                  end else begin
                     t1_run_in   = 1'b0;
                     t1_count_in = via_pkg::TIMER_STOPPED;
                  end
               end else begin
                  t1_count_in = t1_count_ff - req_tick_cycles;
               end
            end
            // timer 2: one-shot, frozen in pulse mode
            if (t2_run_ff && !acr_ff[via_pkg::ACR_T2_PULSE]) begin
               if (t2_expire) begin
                  fired       = 1'b1;
                  t2_run_in   = 1'b0;
                  t2_count_in = via_pkg::TIMER_STOPPED;
               end else begin
                  t2_count_in = t2_count_ff - req_tick_cycles;
               end
            end
            flags_in = flags_ff | (t1_expire ? via_pkg::FLAG_T1 : 7'h00)
                                | (t2_expire ? via_pkg::FLAG_T2 : 7'h00);
         end
         via_pkg::MODE_PORT_A: ext_a_in = req_write_data;
         via_pkg::MODE_PORT_B: ext_b_in = req_write_data;
         via_pkg::MODE_CA1: begin
            ca1_in = req_line_level;
            if (pcr_ff[via_pkg::PCR_CA1_RISE] ? (req_line_level && !ca1_ff)
                                              : (!req_line_level && ca1_ff)) begin
               flags_in = flags_ff | via_pkg::FLAG_CA1;
            end
         end
         via_pkg::MODE_CB1: begin
            cb1_in = req_line_level;
            if (pcr_ff[via_pkg::PCR_CB1_RISE] ? (req_line_level && !cb1_ff)
                                              : (!req_line_level && cb1_ff)) begin
               flags_in = flags_ff | via_pkg::FLAG_CB1;
            end
         end
         default: begin
         end
      endcase

      // response fields from the updated state
      irq_in    = fired | (|(flags_in & ier_in));
      pins_a_in = (ora_in & ddra_in) | (ext_a_in & ~ddra_in);
      pins_b_in = (orb_in & ddrb_in) | (ext_b_in & ~ddrb_in);
      if (acr_in[via_pkg::ACR_PB7_OUT]) begin
         pins_b_in[7] = t1_pb7_in;
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ora_ff       <= 8'h00;
         orb_ff       <= 8'h00;
         ddra_ff      <= 8'h00;
         ddrb_ff      <= 8'h00;
         ext_a_ff     <= via_pkg::EXT_RESET;
         ext_b_ff     <= via_pkg::EXT_RESET;
         t1_latch_ff  <= 16'h0000;
         t1_count_ff  <= 16'h0000;
         t1_run_ff    <= 1'b0;
         t1_pb7_ff    <= 1'b0;
         t2_low_ff    <= 8'h00;
         t2_count_ff  <= 16'h0000;
         t2_run_ff    <= 1'b0;
         sr_ff        <= 8'h00;
         acr_ff       <= 8'h00;
         pcr_ff       <= 8'h00;
         flags_ff     <= 7'h00;
         ier_ff       <= 7'h00;
         ca1_ff       <= 1'b1;
         cb1_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ora_ff      <= ora_in;
            orb_ff      <= orb_in;
            ddra_ff     <= ddra_in;
            ddrb_ff     <= ddrb_in;
            ext_a_ff    <= ext_a_in;
            ext_b_ff    <= ext_b_in;
            t1_latch_ff <= t1_latch_in;
            t1_count_ff <= t1_count_in;
            t1_run_ff   <= t1_run_in;
            t1_pb7_ff   <= t1_pb7_in;
            t2_low_ff   <= t2_low_in;
            t2_count_ff <= t2_count_in;
            t2_run_ff   <= t2_run_in;
            sr_ff       <= sr_in;
            acr_ff      <= acr_in;
            pcr_ff      <= pcr_in;
            flags_ff    <= flags_in;
            ier_ff      <= ier_in;
            ca1_ff      <= ca1_in;
            cb1_ff      <= cb1_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // response payload, no reset needed
      if (accept) begin
         rd_ff     <= rd_in;
         irq_ff    <= irq_in;
         pins_a_ff <= pins_a_in;
         pins_b_ff <= pins_b_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rd_ff;
   assign rsp_irq_out     = irq_ff;
   assign rsp_port_a_pins = pins_a_ff;
   assign rsp_port_b_pins = pins_b_ff;

endmodule
